@@ hdl/csvt_pkg.sv @@
// csvt_pkg: shared constants and types for the CSV field tokenizer.
// Used by csvt_decode and csv_field_tokenizer_core; depends on nothing.
package csvt_pkg;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // parser state codes
    localparam logic [2:0] ST_START = 3'd0;
    localparam logic [2:0] ST_UNQ   = 3'd1;
    localparam logic [2:0] ST_INQ   = 3'd2;
    localparam logic [2:0] ST_QSEEN = 3'd3;
    localparam logic [2:0] ST_AFTER = 3'd4;
    localparam logic [2:0] ST_DROP  = 3'd5;

    // result kinds
    localparam logic [1:0] K_DATA = 2'd0;
    localparam logic [1:0] K_FEND = 2'd1;
    localparam logic [1:0] K_REND = 2'd2;
    localparam logic [1:0] K_ERR  = 2'd3;

    // result queue
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] byte_out;
        logic       last;
    } result_t;

    // decode of one byte: up to two results plus the next state
    typedef struct packed {
        logic [1:0] n;
        result_t    r0;
        result_t    r1;
        logic [2:0] next_state;
    } dec_t;

endpackage

@@ hdl/csvt_decode.sv @@
// csvt_decode: per-byte decision logic of the CSV tokenizer.
// Pure combinational; depends on csvt_pkg.
module csvt_decode (
    input  logic [2:0]      state,
    input  logic [7:0]      byte_in,
    output csvt_pkg::dec_t  dec
);

    logic blank;
    logic line_end;
    logic [1:0] k0;
    logic [1:0] k1;

    assign blank    = (byte_in == csvt_pkg::CH_SPACE) || (byte_in == csvt_pkg::CH_TAB);
    assign line_end = (byte_in == csvt_pkg::CH_LF) || (byte_in == csvt_pkg::CH_CR);

    always_comb
    begin
        dec.n          = 2'd0;
        dec.next_state = state;
        k0             = csvt_pkg::K_DATA;
        k1             = csvt_pkg::K_DATA;
        case (state)
            csvt_pkg::ST_UNQ:
            begin
                dec.n = 2'd1;
                if (byte_in == csvt_pkg::CH_COMMA)
                begin
                    k0             = csvt_pkg::K_FEND;
                    dec.next_state = csvt_pkg::ST_START;
                end
                else if (byte_in == csvt_pkg::CH_NUL)
                begin
                    k0             = csvt_pkg::K_REND;
                    dec.next_state = csvt_pkg::ST_START;
                end
                else if (line_end)
                begin
                    k0             = csvt_pkg::K_REND;
                    dec.next_state = csvt_pkg::ST_DROP;
                end
            end
            csvt_pkg::ST_INQ:
            begin
                if (byte_in == csvt_pkg::CH_NUL)
                begin
                    dec.n          = 2'd1;
                    k0             = csvt_pkg::K_ERR;
                    dec.next_state = csvt_pkg::ST_START;
                end
                else if (byte_in == csvt_pkg::CH_QUOTE)
                begin
                    dec.next_state = csvt_pkg::ST_QSEEN;
                end
                else
                begin
                    dec.n = 2'd1;
                end
            end
            csvt_pkg::ST_QSEEN, csvt_pkg::ST_AFTER:
            begin
                if (state == csvt_pkg::ST_QSEEN && byte_in == csvt_pkg::CH_QUOTE)
                begin
                    // doubled quote: one literal quote
                    dec.n          = 2'd1;
                    dec.next_state = csvt_pkg::ST_INQ;
                end
                else if (blank)
                begin
                    dec.next_state = csvt_pkg::ST_AFTER;
                end
                else if (byte_in == csvt_pkg::CH_COMMA)
                begin
                    dec.n          = 2'd1;
                    k0             = csvt_pkg::K_FEND;
                    dec.next_state = csvt_pkg::ST_START;
                end
                else if (byte_in == csvt_pkg::CH_NUL)
                begin
                    dec.n          = 2'd1;
                    k0             = csvt_pkg::K_REND;
                    dec.next_state = csvt_pkg::ST_START;
                end
                else if (line_end)
                begin
                    dec.n          = 2'd1;
                    k0             = csvt_pkg::K_REND;
                    dec.next_state = csvt_pkg::ST_DROP;
                end
                else if (byte_in == csvt_pkg::CH_QUOTE)
                begin
                    // field end, then a new quoted field opens
                    dec.n          = 2'd1;
                    k0             = csvt_pkg::K_FEND;
                    dec.next_state = csvt_pkg::ST_INQ;
                end
                else
                begin
                    // field end, then this byte starts an unquoted field
                    dec.n          = 2'd2;
                    k0             = csvt_pkg::K_FEND;
                    k1             = csvt_pkg::K_DATA;
                    dec.next_state = csvt_pkg::ST_UNQ;
                end
            end
            csvt_pkg::ST_DROP:
            begin
                if (byte_in == csvt_pkg::CH_NUL)
                begin
                    dec.next_state = csvt_pkg::ST_START;
                end
            end
            default:
            begin
                // field start; unused codes land here too
                dec.next_state = csvt_pkg::ST_START;
                if (blank)
                begin
                    dec.n = 2'd0;
                end
                else if (byte_in == csvt_pkg::CH_NUL)
                begin
                    dec.n = 2'd1;
                    k0    = csvt_pkg::K_REND;
                end
                else if (line_end)
                begin
                    dec.n          = 2'd1;
                    k0             = csvt_pkg::K_REND;
                    dec.next_state = csvt_pkg::ST_DROP;
                end
                else if (byte_in == csvt_pkg::CH_QUOTE)
                begin
                    dec.next_state = csvt_pkg::ST_INQ;
                end
                else if (byte_in == csvt_pkg::CH_COMMA)
                begin
                    dec.n = 2'd1;
                    k0    = csvt_pkg::K_FEND;
                end
                else
                begin
                    dec.n          = 2'd1;
                    dec.next_state = csvt_pkg::ST_UNQ;
                end
            end
        endcase

        dec.r0.kind     = k0;
        dec.r0.byte_out = (k0 == csvt_pkg::K_DATA) ? byte_in : 8'h00;
        dec.r0.last     = (dec.n == 2'd1);
        dec.r1.kind     = k1;
        dec.r1.byte_out = (k1 == csvt_pkg::K_DATA) ? byte_in : 8'h00;
        dec.r1.last     = 1'b1;
    end

endmodule

@@ hdl/csv_field_tokenizer_core.sv @@
// csv_field_tokenizer_core: top level of the streaming CSV field tokenizer.
// Depends on csvt_pkg and csvt_decode.

// One record's bytes enter one word per cycle while in_ready is high; byte
// 0 ends the record. Each byte yields zero, one or two result words (data
// byte, field end, record end, or unterminated-quote error), with last set
// on the final word a byte causes. A byte goes into an input register, is
// decoded against the parser state and its results are written into a
// four-entry result queue that drives the output. The block takes one byte
// per cycle while the queue holds two words or fewer, so with a free-running
// output and no two-word bytes the rate is one byte per cycle. A byte waits
// in the input register until the queue has room; its results are valid once
// written to the queue. No clearing pass; state is ready right after reset.
module csv_field_tokenizer_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] byte_in,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] kind,
    output logic [7:0] byte_out,
    output logic       last
);

    logic                     hold_valid_reg;
    logic [7:0]               hold_byte_reg;
    logic [2:0]               state_reg;
    csvt_pkg::result_t        q_reg [csvt_pkg::QDEPTH];
    logic [csvt_pkg::QAW-1:0] wr_ptr_reg;
    logic [csvt_pkg::QAW-1:0] rd_ptr_reg;
    logic [csvt_pkg::QCW-1:0] count_reg;
    logic [csvt_pkg::QCW-1:0] count_next;

    csvt_pkg::dec_t           dec;
    csvt_pkg::result_t        head;
    logic                     consume;
    logic                     pop;
    logic                     in_take;

    csvt_decode u_decode (
        .state   (state_reg),
        .byte_in (hold_byte_reg),
        .dec     (dec)
    );

    // room for the worst case of two words before a held byte is decoded
    assign consume  = hold_valid_reg &&
                      (count_reg <= csvt_pkg::QCW'(csvt_pkg::QDEPTH - 2));
    assign in_ready = !hold_valid_reg || consume;
    assign in_take  = in_valid && in_ready;

    assign head      = q_reg[rd_ptr_reg];
    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;
    assign kind      = head.kind;
    assign byte_out  = head.byte_out;
    assign last      = head.last;

    always_comb
    begin
        count_next = count_reg - csvt_pkg::QCW'(pop);
        if (consume)
        begin
            count_next = count_next + csvt_pkg::QCW'(dec.n);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            state_reg      <= csvt_pkg::ST_START;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
        end
        else
        begin
            if (in_take)
            begin
                hold_valid_reg <= 1'b1;
            end
            else if (consume)
            begin
                hold_valid_reg <= 1'b0;
            end
            if (consume)
            begin
                state_reg  <= dec.next_state;
                wr_ptr_reg <= wr_ptr_reg + csvt_pkg::QAW'(dec.n);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + csvt_pkg::QAW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            hold_byte_reg <= byte_in;
        end
        if (consume && dec.n != 2'd0)
        begin
            q_reg[wr_ptr_reg] <= dec.r0;
        end
        if (consume && dec.n == 2'd2)
        begin
            q_reg[wr_ptr_reg + csvt_pkg::QAW'(1)] <= dec.r1;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= csvt_pkg::QCW'(csvt_pkg::QDEPTH))
        else $error("result queue overflow");

    a_state_legal: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg <= csvt_pkg::ST_DROP)
        else $error("parser state left the used codes");

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == csvt_pkg::K_ERR |-> last)
        else $error("error word not marked last");

    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != csvt_pkg::K_DATA |-> byte_out == 8'h00)
        else $error("non-data word carries a byte");

    a_first_of_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> kind == csvt_pkg::K_FEND)
        else $error("first of a word pair is not a field end");

endmodule

@@ dv/csv_field_tokenizer_core_tb.sv @@
// csv_field_tokenizer_core_tb: self-checking testbench for the CSV field tokenizer.
// Directed and random records go in, and every output word is checked against an
// in-bench parser model. Depends on csvt_pkg and csv_field_tokenizer_core.
module csv_field_tokenizer_core_tb;

    // Tracks the parser state and holds the tokens still owed by the block.
    class token_scoreboard;
        csvt_pkg::result_t pending_tokens[$];
        csvt_pkg::result_t step_tokens[$];
        logic [2:0]        parse_state;
        int                fail_count;

        function new();
            parse_state = csvt_pkg::ST_START;
            fail_count  = 0;
        endfunction

        function void add_token(logic [1:0] k, logic [7:0] b);
            csvt_pkg::result_t t;
            t.kind     = k;
            t.byte_out = (k == csvt_pkg::K_DATA) ? b : 8'h00;
            t.last     = 1'b0;
            step_tokens.push_back(t);
        endfunction

        function bit is_line_end(logic [7:0] b);
            return (b == csvt_pkg::CH_LF) || (b == csvt_pkg::CH_CR);
        endfunction

        function void open_field(logic [7:0] b);
            if (b == csvt_pkg::CH_SPACE || b == csvt_pkg::CH_TAB)
            begin
                parse_state = csvt_pkg::ST_START;
            end
            else if (b == csvt_pkg::CH_NUL)
            begin
                add_token(csvt_pkg::K_REND, 8'h00);
                parse_state = csvt_pkg::ST_START;
            end
            else if (is_line_end(b))
            begin
                add_token(csvt_pkg::K_REND, 8'h00);
                parse_state = csvt_pkg::ST_DROP;
            end
            else if (b == csvt_pkg::CH_QUOTE)
            begin
                parse_state = csvt_pkg::ST_INQ;
            end
            else if (b == csvt_pkg::CH_COMMA)
            begin
                add_token(csvt_pkg::K_FEND, 8'h00);
                parse_state = csvt_pkg::ST_START;
            end
            else
            begin
                add_token(csvt_pkg::K_DATA, b);
                parse_state = csvt_pkg::ST_UNQ;
            end
        endfunction

        // byte after a closed quoted field
        function void close_quoted(logic [7:0] b);
            if (b == csvt_pkg::CH_SPACE || b == csvt_pkg::CH_TAB)
            begin
                parse_state = csvt_pkg::ST_AFTER;
            end
            else if (b == csvt_pkg::CH_COMMA)
            begin
                add_token(csvt_pkg::K_FEND, 8'h00);
                parse_state = csvt_pkg::ST_START;
            end
            else if (b == csvt_pkg::CH_NUL)
            begin
                add_token(csvt_pkg::K_REND, 8'h00);
                parse_state = csvt_pkg::ST_START;
            end
            else if (is_line_end(b))
            begin
                add_token(csvt_pkg::K_REND, 8'h00);
                parse_state = csvt_pkg::ST_DROP;
            end
            else
            begin
                add_token(csvt_pkg::K_FEND, 8'h00);
                open_field(b);
            end
        endfunction

        function void absorb_byte(logic [7:0] b);
            csvt_pkg::result_t t;
            step_tokens.delete();
            case (parse_state)
                csvt_pkg::ST_UNQ:
                begin
                    if (b == csvt_pkg::CH_COMMA)
                    begin
                        add_token(csvt_pkg::K_FEND, 8'h00);
                        parse_state = csvt_pkg::ST_START;
                    end
                    else if (b == csvt_pkg::CH_NUL)
                    begin
                        add_token(csvt_pkg::K_REND, 8'h00);
                        parse_state = csvt_pkg::ST_START;
                    end
                    else if (is_line_end(b))
                    begin
                        add_token(csvt_pkg::K_REND, 8'h00);
                        parse_state = csvt_pkg::ST_DROP;
                    end
                    else
                    begin
                        add_token(csvt_pkg::K_DATA, b);
                    end
                end
                csvt_pkg::ST_INQ:
                begin
                    if (b == csvt_pkg::CH_NUL)
                    begin
                        add_token(csvt_pkg::K_ERR, 8'h00);
                        parse_state = csvt_pkg::ST_START;
                    end
                    else if (b == csvt_pkg::CH_QUOTE)
                    begin
                        parse_state = csvt_pkg::ST_QSEEN;
                    end
                    else
                    begin
                        add_token(csvt_pkg::K_DATA, b);
                    end
                end
                csvt_pkg::ST_QSEEN:
                begin
                    if (b == csvt_pkg::CH_QUOTE)
                    begin
                        add_token(csvt_pkg::K_DATA, csvt_pkg::CH_QUOTE);
                        parse_state = csvt_pkg::ST_INQ;
                    end
                    else
                    begin
                        close_quoted(b);
                    end
                end
                csvt_pkg::ST_AFTER: close_quoted(b);
                csvt_pkg::ST_DROP:
                begin
                    if (b == csvt_pkg::CH_NUL)
                        parse_state = csvt_pkg::ST_START;
                end
                default: open_field(b);
            endcase
            foreach (step_tokens[i])
            begin
                t      = step_tokens[i];
                t.last = (i == step_tokens.size() - 1);
                pending_tokens.push_back(t);
            end
        endfunction

        function void check_token(csvt_pkg::result_t got);
            csvt_pkg::result_t exp_t;
            if (pending_tokens.size() == 0)
            begin
                $error("unexpected word: kind %0d byte_out 0x%02h last %0d",
                       got.kind, got.byte_out, got.last);
                fail_count++;
                return;
            end
            exp_t = pending_tokens.pop_front();
            if (got.kind !== exp_t.kind)
            begin
                $error("kind mismatch: expected %0d, actual %0d", exp_t.kind, got.kind);
                fail_count++;
            end
            if (got.byte_out !== exp_t.byte_out)
            begin
                $error("byte_out mismatch: expected 0x%02h, actual 0x%02h",
                       exp_t.byte_out, got.byte_out);
                fail_count++;
            end
            if (got.last !== exp_t.last)
            begin
                $error("last mismatch: expected %0d, actual %0d", exp_t.last, got.last);
                fail_count++;
            end
        endfunction

        function int pending_count();
            return pending_tokens.size();
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] byte_in;
    logic       out_valid;
    logic       out_ready;
    logic [1:0] kind;
    logic [7:0] byte_out;
    logic       last;

    token_scoreboard sb = new();
    bit              idle_on = 1'b1;
    int              bytes_sent = 0;
    logic [7:0]      record_bytes[$];

    csv_field_tokenizer_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .byte_in  (byte_in),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .kind     (kind),
        .byte_out (byte_out),
        .last     (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("csv_field_tokenizer_core test failed");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 11);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        byte_in  <= b;
        do @(posedge clk); while (!in_ready);
        sb.absorb_byte(b);
        bytes_sent++;
    endtask

    // hold off the input until every owed word has come out
    task automatic drain_outputs();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending_count() != 0);
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(1, 255));
        while (b == csvt_pkg::CH_COMMA || b == csvt_pkg::CH_QUOTE ||
               b == csvt_pkg::CH_LF || b == csvt_pkg::CH_CR);
        return b;
    endfunction

    function automatic logic [7:0] blank_byte();
        return $urandom_range(0, 1) ? csvt_pkg::CH_SPACE : csvt_pkg::CH_TAB;
    endfunction

    function automatic logic [7:0] line_end_byte();
        return $urandom_range(0, 1) ? csvt_pkg::CH_LF : csvt_pkg::CH_CR;
    endfunction

    function automatic logic [7:0] quoted_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(1, 255));
        while (b == csvt_pkg::CH_QUOTE);
        return b;
    endfunction

    task automatic push_blanks();
        int n;
        n = $urandom_range(1, 2);
        repeat (n) record_bytes.push_back(blank_byte());
    endtask

    // record with random content and a random ending, well-formed or an unterminated quote
    task automatic build_record();
        int nfields;
        int len;
        int r;
        nfields = $urandom_range(1, 5);
        for (int f = 0; f < nfields; f++)
        begin
            if ($urandom_range(0, 3) == 0)
                push_blanks();
            if ($urandom_range(0, 2) == 0)
            begin
                record_bytes.push_back(csvt_pkg::CH_QUOTE);
                len = $urandom_range(0, 6);
                repeat (len)
                begin
                    r = $urandom_range(0, 9);
                    if (r == 0)
                    begin
                        record_bytes.push_back(csvt_pkg::CH_QUOTE);
                        record_bytes.push_back(csvt_pkg::CH_QUOTE);
                    end
                    else if (r == 1)
                    begin
                        record_bytes.push_back(csvt_pkg::CH_COMMA);
                    end
                    else if (r == 2)
                    begin
                        record_bytes.push_back(line_end_byte());
                    end
                    else
                    begin
                        record_bytes.push_back(quoted_byte());
                    end
                end
                record_bytes.push_back(csvt_pkg::CH_QUOTE);
                if ($urandom_range(0, 3) == 0)
                    push_blanks();
            end
            else
            begin
                len = $urandom_range(0, 6);
                repeat (len) record_bytes.push_back(plain_byte());
                if ($urandom_range(0, 4) == 0)
                    record_bytes.push_back(csvt_pkg::CH_SPACE);
            end
            if (f < nfields - 1 || $urandom_range(0, 5) == 0)
                record_bytes.push_back(csvt_pkg::CH_COMMA);
        end
        r = $urandom_range(0, 5);
        if (r == 4)
        begin
            record_bytes.push_back(line_end_byte());
            len = $urandom_range(0, 4);
            repeat (len) record_bytes.push_back(8'($urandom_range(1, 255)));
        end
        else if (r == 5)
        begin
            // unterminated quote
            record_bytes.push_back(csvt_pkg::CH_QUOTE);
            len = $urandom_range(0, 3);
            repeat (len) record_bytes.push_back(quoted_byte());
        end
        record_bytes.push_back(csvt_pkg::CH_NUL);
    endtask

    task automatic build_noise();
        int len;
        len = $urandom_range(1, 16);
        repeat (len) record_bytes.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1) == 0)
            record_bytes.push_back(csvt_pkg::CH_NUL);
    endtask

    // output side: check accepted words, stall in random bursts
    initial
    begin
        int                stall_left;
        csvt_pkg::result_t got;
        stall_left = 0;
        out_ready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                got.kind     = kind;
                got.byte_out = byte_out;
                got.last     = last;
                sb.check_token(got);
            end
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                out_ready  <= 1'b0;
                stall_left = $urandom_range(0, 10);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        logic [7:0] directed[$];
        bit         drained_once;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        byte_in      = 8'h00;
        drained_once = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty records, drop after line end, blanks, quoted content with doubled
        // quote, quote after close, data after close, CR end, error, trailing comma
        directed = '{8'h00, csvt_pkg::CH_LF, 8'hFF, 8'h00, csvt_pkg::CH_TAB,
                     csvt_pkg::CH_COMMA, csvt_pkg::CH_QUOTE, csvt_pkg::CH_COMMA,
                     csvt_pkg::CH_CR, csvt_pkg::CH_QUOTE, csvt_pkg::CH_QUOTE,
                     csvt_pkg::CH_QUOTE, csvt_pkg::CH_SPACE, csvt_pkg::CH_QUOTE,
                     csvt_pkg::CH_QUOTE, 8'hFF, csvt_pkg::CH_SPACE, csvt_pkg::CH_CR,
                     8'h00, csvt_pkg::CH_QUOTE, 8'h00, 8'h41, csvt_pkg::CH_COMMA,
                     8'h00};
        foreach (directed[i])
            send_byte(directed[i]);
        drain_outputs();

        while (bytes_sent < 1600)
        begin
            record_bytes.delete();
            if ($urandom_range(0, 4) == 0)
                build_noise();
            else
                build_record();
            foreach (record_bytes[i])
                send_byte(record_bytes[i]);
            if (bytes_sent >= 1400)
                idle_on = 1'b0;
            if ((!drained_once && bytes_sent >= 800) ||
                (idle_on && $urandom_range(0, 24) == 0))
            begin
                drained_once = 1'b1;
                drain_outputs();
            end
        end

        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending_count() != 0);
        repeat (8) @(posedge clk);
        if (sb.fail_count == 0 && sb.pending_count() == 0)
            $display("csv_field_tokenizer_core test passed");
        else
            $display("csv_field_tokenizer_core test failed");
        $finish;
    end

endmodule
